>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL in this folder.
// Compile with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/slt_pkg.sv
`timescale 1ns / 1ps

package slt_pkg;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_BEGIN = 3'd1;
    localparam logic [2:0] CMD_RUN   = 3'd2;
    localparam logic [2:0] CMD_EXIT  = 3'd3;
    localparam logic [2:0] CMD_FAIL  = 3'd4;
    localparam logic [2:0] CMD_GET   = 3'd5;

    localparam logic [2:0] PH_UNUSED  = 3'd0;
    localparam logic [2:0] PH_READY   = 3'd1;
    localparam logic [2:0] PH_RUNNING = 3'd2;
    localparam logic [2:0] PH_EXITED  = 3'd3;
    localparam logic [2:0] PH_FAILED  = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef struct packed {
        logic [31:0]        id;
        logic [2:0]         phase;
        logic signed [31:0] ret_code;
        logic [31:0]        image;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_REUSE,
        SCAN_MARK,
        SCAN_RANK
    } t_scan_mode;

    typedef struct packed {
        t_scan_mode  mode;
        logic        used;
        logic [7:0]  seen;
    } t_probe;

    typedef struct packed {
        logic hit;
        logic skip;
    } t_match;

endpackage

>>> rtl/core/process_slot_table.sv
`timescale 1ns / 1ps

// Slot table with a command port. A request is taken when start is high and
// busy is low; its single result appears for exactly one cycle with o_valid
// high and cannot be held off, so the receiver must take it then. Clear and
// unknown commands answer in the cycle after the request. Begin, mark and get
// walk the slot memory through its one read port, one slot per cycle. Each
// slot is read, then compared in the stage behind the read; the scan stops at
// the first match, or misses once every slot is compared. For these requests
// busy stays high from the request until its result shows. A new request may
// be issued in the cycle its predecessor's result is shown.
module process_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic [31:0]        i_target_id,
    input  logic signed [31:0] i_exit_value,
    input  logic [31:0]        i_image_bytes,
    input  logic [7:0]         i_nth,
    output logic               o_valid,
    output logic               o_status,
    output logic [31:0]        o_rec_id,
    output logic [2:0]         o_rec_state,
    output logic signed [31:0] o_rec_exit,
    output logic [31:0]        o_rec_image,
    output logic [7:0]         o_used_count
);

`include "assert_macros.svh"

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + IW'(1);
    endfunction

    t_state               r_state, n_state;
    logic [SLOTS-1:0]     r_used, n_used;
    logic [CW-1:0]        r_used_cnt, n_used_cnt;
    logic [31:0]          r_id_ctr, n_id_ctr;
    logic [IW-1:0]        r_cursor, n_cursor;
    slt_pkg::t_scan_mode  r_mode, n_mode;
    logic [2:0]           r_cmd, n_cmd;
    logic [31:0]          r_target, n_target;
    logic signed [31:0]   r_exit, n_exit;
    logic [31:0]          r_image, n_image;
    logic [7:0]           r_nth, n_nth;
    logic [IW-1:0]        r_addr, n_addr;
    logic [CW-1:0]        r_iss, n_iss;
    logic                 r_chk_vld, n_chk_vld;
    logic [IW-1:0]        r_chk_addr, n_chk_addr;
    logic                 r_chk_last, n_chk_last;
    logic [7:0]           r_seen, n_seen;
    logic                 r_valid, n_valid;
    logic                 r_status, n_status;
    logic [31:0]          r_rec_id, n_rec_id;
    logic [2:0]           r_rec_state, n_rec_state;
    logic signed [31:0]   r_rec_exit, n_rec_exit;
    logic [31:0]          r_rec_image, n_rec_image;

    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [slt_pkg::ENTRY_W-1:0] ram_rd_data;
    slt_pkg::t_entry            rd_entry;
    slt_pkg::t_entry            wr_entry;
    slt_pkg::t_probe            probe;
    slt_pkg::t_match            match;
    logic                       stop;
    logic                       issue;
    logic                       scan_cmd;

    assign rd_entry = slt_pkg::t_entry'(ram_rd_data);
    assign scan_cmd = (i_cmd != slt_pkg::CMD_CLEAR) && (i_cmd <= slt_pkg::CMD_GET);

    slt_ram #(
        .WIDTH (slt_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_chk_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rd_data)
    );

    assign probe.mode = r_mode;
    assign probe.used = r_used[r_chk_addr];
    assign probe.seen = r_seen;

    slt_match u_match (
        .i_probe     (probe),
        .i_entry     (rd_entry),
        .i_target_id (r_target),
        .i_nth       (r_nth),
        .o_match     (match)
    );

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_used_cnt  = r_used_cnt;
        n_id_ctr    = r_id_ctr;
        n_cursor    = r_cursor;
        n_mode      = r_mode;
        n_cmd       = r_cmd;
        n_target    = r_target;
        n_exit      = r_exit;
        n_image     = r_image;
        n_nth       = r_nth;
        n_addr      = r_addr;
        n_iss       = r_iss;
        n_chk_vld   = r_chk_vld;
        n_chk_addr  = r_chk_addr;
        n_chk_last  = r_chk_last;
        n_seen      = r_seen;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_rec_id    = r_rec_id;
        n_rec_state = r_rec_state;
        n_rec_exit  = r_rec_exit;
        n_rec_image = r_rec_image;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        wr_entry    = rd_entry;
        stop        = 1'b0;
        issue       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd       = i_cmd;
                    n_target    = i_target_id;
                    n_exit      = i_exit_value;
                    n_image     = i_image_bytes;
                    n_nth       = i_nth;
                    n_addr      = '0;
                    n_iss       = '0;
                    n_chk_vld   = 1'b0;
                    n_chk_last  = 1'b0;
                    n_seen      = '0;
                    n_status    = slt_pkg::STATUS_MISS;
                    n_rec_id    = '0;
                    n_rec_state = slt_pkg::PH_UNUSED;
                    n_rec_exit  = '0;
                    n_rec_image = '0;
                    case (i_cmd)
                        slt_pkg::CMD_CLEAR: begin
                            n_used     = '0;
                            n_used_cnt = '0;
                            n_id_ctr   = 32'd1;
                            n_cursor   = '0;
                            n_status   = slt_pkg::STATUS_OK;
                            n_valid    = 1'b1;
                        end
                        slt_pkg::CMD_BEGIN: begin
                            if (r_used_cnt == SLOTS_C) begin
                                // full: hunt for a finished entry from the cursor
                                n_mode = slt_pkg::SCAN_REUSE;
                                n_addr = r_cursor;
                            end else begin
                                n_mode = slt_pkg::SCAN_FREE;
                            end
                            n_state = ST_SCAN;
                        end
                        slt_pkg::CMD_RUN, slt_pkg::CMD_EXIT, slt_pkg::CMD_FAIL: begin
                            n_mode  = slt_pkg::SCAN_MARK;
                            n_state = ST_SCAN;
                        end
                        slt_pkg::CMD_GET: begin
                            n_mode  = slt_pkg::SCAN_RANK;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                stop      = r_chk_vld && (match.hit || r_chk_last);
                issue     = !stop && (r_iss != SLOTS_C);
                ram_rd_en = issue;

                // read one slot ahead of the compare
                if (issue) begin
                    n_addr     = next_idx(r_addr);
                    n_iss      = r_iss + CW'(1);
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_addr;
                    n_chk_last = (r_iss == SLOTS_C - CW'(1));
                end else begin
                    n_chk_vld  = 1'b0;
                end

                if (r_chk_vld && match.skip) begin
                    n_seen = r_seen + 8'd1;
                end

                if (stop) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    if (match.hit) begin
                        n_status = slt_pkg::STATUS_OK;
                        case (r_mode)
                            slt_pkg::SCAN_FREE, slt_pkg::SCAN_REUSE: begin
                                wr_entry.id       = r_id_ctr;
                                wr_entry.phase    = slt_pkg::PH_READY;
                                wr_entry.ret_code = '0;
                                wr_entry.image    = r_image;
                                ram_wr_en         = 1'b1;
                                n_rec_id          = r_id_ctr;
                                n_id_ctr = (r_id_ctr == '1) ? 32'd1 : r_id_ctr + 32'd1;
                                if (r_mode == slt_pkg::SCAN_FREE) begin
                                    n_used[r_chk_addr] = 1'b1;
                                    n_used_cnt         = r_used_cnt + CW'(1);
                                end else begin
                                    n_cursor = next_idx(r_chk_addr);
                                end
                            end
                            slt_pkg::SCAN_MARK: begin
                                ram_wr_en = 1'b1;
                                case (r_cmd)
                                    slt_pkg::CMD_RUN: begin
                                        wr_entry.phase = slt_pkg::PH_RUNNING;
                                    end
                                    slt_pkg::CMD_EXIT: begin
                                        wr_entry.phase    = slt_pkg::PH_EXITED;
                                        wr_entry.ret_code = r_exit;
                                    end
                                    default: begin
                                        wr_entry.phase    = slt_pkg::PH_FAILED;
                                        wr_entry.ret_code = r_exit;
                                    end
                                endcase
                            end
                            default: begin
                                n_rec_id    = rd_entry.id;
                                n_rec_state = rd_entry.phase;
                                n_rec_exit  = rd_entry.ret_code;
                                n_rec_image = rd_entry.image;
                            end
                        endcase
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used     <= '0;
            r_used_cnt <= '0;
            r_id_ctr   <= 32'd1;
            r_cursor   <= '0;
            r_chk_vld  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_used_cnt <= n_used_cnt;
            r_id_ctr   <= n_id_ctr;
            r_cursor   <= n_cursor;
            r_chk_vld  <= n_chk_vld;
            r_valid    <= n_valid;
        end
        r_mode      <= n_mode;
        r_cmd       <= n_cmd;
        r_target    <= n_target;
        r_exit      <= n_exit;
        r_image     <= n_image;
        r_nth       <= n_nth;
        r_addr      <= n_addr;
        r_iss       <= n_iss;
        r_chk_addr  <= n_chk_addr;
        r_chk_last  <= n_chk_last;
        r_seen      <= n_seen;
        r_status    <= n_status;
        r_rec_id    <= n_rec_id;
        r_rec_state <= n_rec_state;
        r_rec_exit  <= n_rec_exit;
        r_rec_image <= n_rec_image;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_rec_id     = r_rec_id;
    assign o_rec_state  = r_rec_state;
    assign o_rec_exit   = r_rec_exit;
    assign o_rec_image  = r_rec_image;
    assign o_used_count = 8'(r_used_cnt);

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_used_cnt <= SLOTS_C)
    `ASSERT_ALWAYS(a_id_nonzero, i_clk, i_rst_n, r_id_ctr != 32'd0)
    `ASSERT_ALWAYS(a_cursor_bound, i_clk, i_rst_n, r_cursor <= LAST_IDX)
    `ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n, start && !busy && scan_cmd, busy && !o_valid)
    `ASSERT_IMPLY(a_wr_on_stop, i_clk, i_rst_n, ram_wr_en, stop && match.hit)

endmodule

>>> rtl/core/slt_ram.sv
`timescale 1ns / 1ps

module slt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/slt_match.sv
`timescale 1ns / 1ps

module slt_match (
    input  slt_pkg::t_probe i_probe,
    input  slt_pkg::t_entry i_entry,
    input  logic [31:0]     i_target_id,
    input  logic [7:0]      i_nth,
    output slt_pkg::t_match o_match
);

    logic hit;

    always_comb begin
        case (i_probe.mode)
            slt_pkg::SCAN_FREE: begin
                hit = !i_probe.used;
            end
            slt_pkg::SCAN_REUSE: begin
                // table is full here, so every entry holds written data
                hit = (i_entry.phase == slt_pkg::PH_EXITED) ||
                      (i_entry.phase == slt_pkg::PH_FAILED);
            end
            slt_pkg::SCAN_MARK: begin
                hit = i_probe.used && (i_entry.id == i_target_id);
            end
            slt_pkg::SCAN_RANK: begin
                hit = i_probe.used && (i_probe.seen == i_nth);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    assign o_match.hit  = hit;
    // count used entries passed over while ranking
    assign o_match.skip = (i_probe.mode == slt_pkg::SCAN_RANK) && i_probe.used && !hit;

endmodule
